### rtl/core/ycc2rgb_pkg.sv
// Shared types, constants and the pixel rounding function of the YCbCr to RGB converter.
package ycc2rgb_pkg;

    // Largest supported line, in pixels.
    localparam int MAX_LINE_WIDTH = 2048;

    // Chroma line store: one entry per pair of columns.
    localparam int STORE_DEPTH = MAX_LINE_WIDTH / 2;
    localparam int COL_W       = $clog2(MAX_LINE_WIDTH);
    localparam int SLOT_W      = $clog2(STORE_DEPTH);

    // Configuration register widths and reset values.
    localparam int LINE_W             = 12;
    localparam int CFG_DATA_W         = 12;
    localparam int CFG_IDX_W          = 1;
    localparam int LINE_WIDTH_RESET   = 640;
    localparam int LINE_WIDTH_MIN     = 2;

    // Width used to compare the column counter against the line width.
    localparam int CMP_W = (LINE_W > COL_W + 1) ? LINE_W : COL_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH     = 1'd1;

    // Arithmetic widths: products of a Q16 coefficient and a 9-bit difference,
    // and sums that add the scaled luma.
    localparam int CHROMA_W = 16;
    localparam int PROD_W   = 26;
    localparam int SUM_W    = 27;

    // Q16 coefficients of the full-range BT.601 matrix.
    localparam logic signed [PROD_W-1:0] K_B_CB = 26'sd116130;
    localparam logic signed [PROD_W-1:0] K_G_CB = 26'sd22554;
    localparam logic signed [PROD_W-1:0] K_G_CR = 26'sd46802;
    localparam logic signed [PROD_W-1:0] K_R_CR = 26'sd91881;

    // Rounding offset and saturation limit.
    localparam logic signed [SUM_W-1:0] ROUND_HALF = 27'sd32768;
    localparam logic signed [SUM_W-1:0] PIXEL_MAX  = 27'sd255;

    // One input word.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } pixel_t;

    // One result word.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // Round a Q16 sum half up and saturate it to 0..255.
    function automatic logic [7:0] to_pixel(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] rounded;
        logic [7:0]              result;
        rounded = (sum + ROUND_HALF) >>> 16;
        if (sum < 0)
        begin
            result = 8'd0;
        end
        else if (rounded > PIXEL_MAX)
        begin
            result = 8'd255;
        end
        else
        begin
            result = rounded[7:0];
        end
        return result;
    endfunction

endpackage

### rtl/core/ycc2rgb_ram.sv
// Generic single-write, single-read memory with a registered read port.
module ycc2rgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     write_enable,
    input  logic [$clog2(DEPTH)-1:0] write_addr,
    input  logic [WIDTH-1:0]         write_data,
    input  logic                     read_enable,
    input  logic [$clog2(DEPTH)-1:0] read_addr,
    output logic [WIDTH-1:0]         read_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] read_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (write_enable)
        begin
            mem_reg[write_addr] <= write_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (read_enable)
        begin
            read_data_reg <= mem_reg[read_addr];
        end
    end

    assign read_data = read_data_reg;

endmodule

### rtl/core/ycbcr_to_rgb_420_upsample_unit.sv
// Top level: YCbCr to full-range RGB converter with 4:2:0 chroma reuse.
// An accepted word passes through the stage 1, stage 2 and output registers before it appears on rgb.
// Throughput: one word per cycle; the only stall is back-pressure from rgb_stall
// through the three pipeline registers (line store read, multiply, sum and round).
// Reset: mode 0, line width 640, column and row parity cleared, pipeline empty.
// The chroma line store is not cleared; there is no clearing pass after reset.
module ycbcr_to_rgb_420_upsample_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pixel_valid,
    output logic                                  pixel_stall,
    input  ycc2rgb_pkg::pixel_t                   pixel,
    output logic                                  rgb_valid,
    input  logic                                  rgb_stall,
    output ycc2rgb_pkg::rgb_t                     rgb,
    input  logic                                  cfg_write_enable,
    input  logic [ycc2rgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ycc2rgb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    logic                              subsample_mode_reg;
    logic [ycc2rgb_pkg::LINE_W-1:0]    line_width_reg;

    // Position and chroma state.
    logic [ycc2rgb_pkg::COL_W-1:0]     col_reg, col_next;
    logic                              row_odd_reg, row_odd_next;
    logic [ycc2rgb_pkg::CHROMA_W-1:0]  held_reg, held_next;

    // Stage 1: accepted word with chroma chosen except for the store path.
    logic                              s1_valid_reg;
    logic [7:0]                        s1_luma_reg;
    logic [ycc2rgb_pkg::CHROMA_W-1:0]  s1_chroma_reg, s1_chroma_next;
    logic                              s1_use_store_reg;

    // Stage 2: products.
    logic                                     s2_valid_reg;
    logic [7:0]                               s2_luma_reg;
    logic signed [ycc2rgb_pkg::PROD_W-1:0]    s2_pb_reg, s2_pgb_reg, s2_pgr_reg, s2_pr_reg;
    logic signed [ycc2rgb_pkg::PROD_W-1:0]    pb_next, pgb_next, pgr_next, pr_next;

    // Output stage.
    logic                              rgb_valid_reg;
    ycc2rgb_pkg::rgb_t                 rgb_reg, rgb_next;

    // Handshake and control.
    logic                              out_ready, s2_ready, s1_ready;
    logic                              s1_adv, s2_adv, accept;
    logic                              even_col;
    logic [ycc2rgb_pkg::SLOT_W-1:0]    slot;
    logic [ycc2rgb_pkg::CHROMA_W-1:0]  chroma_in, store_data, chroma_sel;
    logic                              ram_we, ram_re;
    logic [ycc2rgb_pkg::CMP_W-1:0]     eff_width, width_ext, col_inc;
    logic signed [8:0]                 db, dr;
    logic signed [ycc2rgb_pkg::SUM_W-1:0] ys, sum_b, sum_g, sum_r;

    // Pipeline flow: each stage moves when the next one is empty or moving.
    assign out_ready   = !rgb_valid_reg || !rgb_stall;
    assign s2_adv      = s2_valid_reg && out_ready;
    assign s2_ready    = !s2_valid_reg || out_ready;
    assign s1_adv      = s1_valid_reg && s2_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel_stall = !s1_ready;
    assign accept      = pixel_valid && s1_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subsample_mode_reg <= 1'b0;
            line_width_reg     <= ycc2rgb_pkg::LINE_W'(ycc2rgb_pkg::LINE_WIDTH_RESET);
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                ycc2rgb_pkg::CFG_SUBSAMPLE_MODE: subsample_mode_reg <= cfg_data[0];
                ycc2rgb_pkg::CFG_LINE_WIDTH:     line_width_reg <= cfg_data[ycc2rgb_pkg::LINE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective width, clamped to the supported range.
    always_comb
    begin
        width_ext = ycc2rgb_pkg::CMP_W'(line_width_reg);
        if (width_ext < ycc2rgb_pkg::CMP_W'(ycc2rgb_pkg::LINE_WIDTH_MIN))
        begin
            eff_width = ycc2rgb_pkg::CMP_W'(ycc2rgb_pkg::LINE_WIDTH_MIN);
        end
        else if (width_ext > ycc2rgb_pkg::CMP_W'(ycc2rgb_pkg::MAX_LINE_WIDTH))
        begin
            eff_width = ycc2rgb_pkg::CMP_W'(ycc2rgb_pkg::MAX_LINE_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
    end

    // Column and row tracking, and chroma selection for the accepted word.
    assign even_col  = !col_reg[0];
    assign slot      = col_reg[ycc2rgb_pkg::COL_W-1:1];
    assign chroma_in = {pixel.chroma_red, pixel.chroma_blue};
    assign col_inc   = ycc2rgb_pkg::CMP_W'(col_reg) + ycc2rgb_pkg::CMP_W'(1);
    assign ram_we    = accept && subsample_mode_reg && !row_odd_reg && even_col;
    assign ram_re    = accept && subsample_mode_reg && row_odd_reg;

    always_comb
    begin
        col_next     = col_reg;
        row_odd_next = row_odd_reg;
        held_next    = ram_we ? chroma_in : held_reg;
        if (accept)
        begin
            if (col_inc >= eff_width)
            begin
                col_next     = '0;
                row_odd_next = !row_odd_reg;
            end
            else
            begin
                col_next = col_inc[ycc2rgb_pkg::COL_W-1:0];
            end
        end
        // In 4:2:0 mode, odd rows take chroma from the store in the next stage.
        if (subsample_mode_reg && !row_odd_reg)
        begin
            s1_chroma_next = held_next;
        end
        else
        begin
            s1_chroma_next = chroma_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_odd_reg <= 1'b0;
            held_reg    <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_odd_reg <= row_odd_next;
            held_reg    <= held_next;
        end
    end

    // Chroma line store, written on even rows and read back on odd rows.
    ycc2rgb_ram #(
        .WIDTH (ycc2rgb_pkg::CHROMA_W),
        .DEPTH (ycc2rgb_pkg::STORE_DEPTH)
    ) u_line_store (
        .clk          (clk),
        .write_enable (ram_we),
        .write_addr   (slot),
        .write_data   (chroma_in),
        .read_enable  (ram_re),
        .read_addr    (slot),
        .read_data    (store_data)
    );

    // Stage 1 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_luma_reg      <= pixel.luma;
            s1_chroma_reg    <= s1_chroma_next;
            s1_use_store_reg <= subsample_mode_reg && row_odd_reg;
        end
    end

    // Chroma differences and constant-coefficient products.
    assign chroma_sel = s1_use_store_reg ? store_data : s1_chroma_reg;
    assign db         = $signed({1'b0, chroma_sel[7:0]}) - 9'sd128;
    assign dr         = $signed({1'b0, chroma_sel[15:8]}) - 9'sd128;
    assign pb_next    = ycc2rgb_pkg::K_B_CB * ycc2rgb_pkg::PROD_W'(db);
    assign pgb_next   = ycc2rgb_pkg::K_G_CB * ycc2rgb_pkg::PROD_W'(db);
    assign pgr_next   = ycc2rgb_pkg::K_G_CR * ycc2rgb_pkg::PROD_W'(dr);
    assign pr_next    = ycc2rgb_pkg::K_R_CR * ycc2rgb_pkg::PROD_W'(dr);

    // Stage 2 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_luma_reg <= s1_luma_reg;
            s2_pb_reg   <= pb_next;
            s2_pgb_reg  <= pgb_next;
            s2_pgr_reg  <= pgr_next;
            s2_pr_reg   <= pr_next;
        end
    end

    // Sums with the scaled luma, then rounding and saturation.
    assign ys    = $signed({3'b000, s2_luma_reg, 16'h0000});
    assign sum_b = ys + ycc2rgb_pkg::SUM_W'(s2_pb_reg);
    assign sum_g = ys - ycc2rgb_pkg::SUM_W'(s2_pgb_reg) - ycc2rgb_pkg::SUM_W'(s2_pgr_reg);
    assign sum_r = ys + ycc2rgb_pkg::SUM_W'(s2_pr_reg);

    always_comb
    begin
        rgb_next.blue  = ycc2rgb_pkg::to_pixel(sum_b);
        rgb_next.green = ycc2rgb_pkg::to_pixel(sum_g);
        rgb_next.red   = ycc2rgb_pkg::to_pixel(sum_r);
    end

    // Output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            rgb_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_reg;

    // The line store is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("line store read and write collide");

    // A held stage 1 word keeps its payload, so the store data it waits on stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_luma_reg)
            && $stable(s1_chroma_reg) && $stable(s1_use_store_reg))
        else $error("stage 1 word changed while held");

    // Input is stalled only when every pipeline stage holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> s1_valid_reg && s2_valid_reg && rgb_valid_reg)
        else $error("input stalled with a free pipeline stage");

    // An accepted word always lands in stage 1.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> s1_valid_reg)
        else $error("accepted word lost");

endmodule

### tb/ycbcr_to_rgb_420_upsample_unit_tb.sv
// Self-checking testbench for the YCbCr to RGB converter with 4:2:0 chroma reuse.
module ycbcr_to_rgb_420_upsample_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Q16 coefficients of the full-range BT.601 conversion.
    localparam longint Q16_BLUE_FROM_CB  = 116130;
    localparam longint Q16_GREEN_FROM_CB = 22554;
    localparam longint Q16_GREEN_FROM_CR = 46802;
    localparam longint Q16_RED_FROM_CR   = 91881;

    // Cycles allowed for the pipeline to drain after the last word.
    localparam int DRAIN_CYCLES = 8;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               pixel_valid = 1'b0;
    logic                               pixel_stall;
    ycc2rgb_pkg::pixel_t                pixel = '0;
    logic                               rgb_valid;
    logic                               rgb_stall = 1'b0;
    ycc2rgb_pkg::rgb_t                  rgb;
    logic                               cfg_write_enable = 1'b0;
    logic [ycc2rgb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ycc2rgb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Words waiting to be sent, with the colors predicted for them.
    ycc2rgb_pkg::pixel_t pending_pixels [$];
    ycc2rgb_pkg::rgb_t   pending_rgb [$];
    // Colors of words the block has taken, oldest first.
    ycc2rgb_pkg::rgb_t   expected_rgb [$];
    ycc2rgb_pkg::rgb_t   driven_rgb = '0;
    ycc2rgb_pkg::rgb_t   want_rgb;

    int sender_idle_pct = 8;
    int receiver_stall_pct = 58;
    int mismatch_count = 0;
    int unsigned queued_items = 0;

    // Shadow of the converter: registers, position counters and chroma memory.
    logic        model_mode = 1'b0;
    int unsigned model_width = ycc2rgb_pkg::LINE_WIDTH_RESET;
    int unsigned model_col = 0;
    logic        model_odd = 1'b0;
    logic [15:0] model_held = '0;
    logic [15:0] chroma_store [ycc2rgb_pkg::STORE_DEPTH];

    ycbcr_to_rgb_420_upsample_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .pixel_valid      (pixel_valid),
        .pixel_stall      (pixel_stall),
        .pixel            (pixel),
        .rgb_valid        (rgb_valid),
        .rgb_stall        (rgb_stall),
        .rgb              (rgb),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #4 clk = ~clk;

    // Round a Q16 sum half up and saturate it to one color byte.
    function automatic logic [7:0] q16_to_byte(input longint sum);
        longint rounded;
        if (sum < 0)
        begin
            return 8'd0;
        end
        rounded = (sum + 32768) >>> 16;
        if (rounded > 255)
        begin
            return 8'd255;
        end
        return rounded[7:0];
    endfunction

    // Convert one word and advance the shadow position and chroma memory.
    function automatic ycc2rgb_pkg::rgb_t convert_pixel(input ycc2rgb_pkg::pixel_t px);
        int unsigned       eff_width;
        int unsigned       slot;
        logic [7:0]        cb;
        logic [7:0]        cr;
        longint            db;
        longint            dr;
        longint            ys;
        ycc2rgb_pkg::rgb_t res;
        eff_width = model_width;
        if (eff_width < ycc2rgb_pkg::LINE_WIDTH_MIN)
        begin
            eff_width = ycc2rgb_pkg::LINE_WIDTH_MIN;
        end
        if (eff_width > ycc2rgb_pkg::MAX_LINE_WIDTH)
        begin
            eff_width = ycc2rgb_pkg::MAX_LINE_WIDTH;
        end
        slot = model_col / 2;
        cb = px.chroma_blue;
        cr = px.chroma_red;
        // In 4:2:0 mode even rows capture chroma at even columns, odd rows replay it.
        if (model_mode)
        begin
            if (!model_odd)
            begin
                if (model_col % 2 == 0)
                begin
                    model_held = {px.chroma_red, px.chroma_blue};
                    chroma_store[slot] = model_held;
                end
                cb = model_held[7:0];
                cr = model_held[15:8];
            end
            else
            begin
                cb = chroma_store[slot][7:0];
                cr = chroma_store[slot][15:8];
            end
        end
        db = longint'(cb) - 128;
        dr = longint'(cr) - 128;
        ys = longint'(px.luma) * 65536;
        res.blue  = q16_to_byte(ys + Q16_BLUE_FROM_CB * db);
        res.green = q16_to_byte(ys - Q16_GREEN_FROM_CB * db - Q16_GREEN_FROM_CR * dr);
        res.red   = q16_to_byte(ys + Q16_RED_FROM_CR * dr);
        // Advance the column; a width shrunk below the column ends the row here.
        model_col = model_col + 1;
        if (model_col >= eff_width)
        begin
            model_col = 0;
            model_odd = ~model_odd;
        end
        return res;
    endfunction

    // Byte with a bias toward the extremes.
    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 7) == 0)
        begin
            return {8{1'($urandom_range(0, 1))}};
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic ycc2rgb_pkg::pixel_t random_pixel();
        ycc2rgb_pkg::pixel_t px;
        px.luma = random_byte();
        px.chroma_blue = random_byte();
        px.chroma_red = random_byte();
        return px;
    endfunction

    function automatic void queue_pixel(input ycc2rgb_pkg::pixel_t px);
        pending_rgb.push_back(convert_pixel(px));
        pending_pixels.push_back(px);
        queued_items++;
    endfunction

    // Send words until the position is back at the start of an even row.
    function automatic void finish_rows();
        while (model_col != 0 || model_odd)
        begin
            queue_pixel(random_pixel());
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Wait until every word has been sent and every color has come back.
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pixel_valid || expected_rgb.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ycc2rgb_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[ycc2rgb_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (idx == ycc2rgb_pkg::CFG_SUBSAMPLE_MODE)
        begin
            model_mode = value[0];
        end
        else if (idx == ycc2rgb_pkg::CFG_LINE_WIDTH)
        begin
            model_width = value & 32'hFFF;
        end
    endtask

    // Sender: keeps a word steady while stalled, otherwise loads the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel <= '0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                expected_rgb.push_back(driven_rgb);
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    pixel <= pending_pixels.pop_front();
                    driven_rgb <= pending_rgb.pop_front();
                    pixel_valid <= 1'b1;
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each taken color word and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_stall <= 1'b0;
        end
        else
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (expected_rgb.size() == 0)
                begin
                    report_mismatch($sformatf("color word %h with none outstanding", rgb));
                end
                else
                begin
                    want_rgb = expected_rgb.pop_front();
                    if (rgb.blue !== want_rgb.blue)
                    begin
                        report_mismatch($sformatf("blue %0d, want %0d", rgb.blue, want_rgb.blue));
                    end
                    if (rgb.green !== want_rgb.green)
                    begin
                        report_mismatch($sformatf("green %0d, want %0d",
                                                  rgb.green, want_rgb.green));
                    end
                    if (rgb.red !== want_rgb.red)
                    begin
                        report_mismatch($sformatf("red %0d, want %0d", rgb.red, want_rgb.red));
                    end
                end
            end
            rgb_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // Stimulus: directed corners first, then random phases of settings.
    initial
    begin : stimulus
        int unsigned         width_reg;
        int unsigned         eff_width;
        int unsigned         count;
        int unsigned         pick;
        logic                mode;
        ycc2rgb_pkg::pixel_t px;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every combination of extreme luma and chroma, then a neutral gray.
        for (int i = 0; i < 8; i++)
        begin
            px.luma = i[0] ? 8'd255 : 8'd0;
            px.chroma_blue = i[1] ? 8'd255 : 8'd0;
            px.chroma_red = i[2] ? 8'd255 : 8'd0;
            queue_pixel(px);
        end
        queue_pixel({8'd128, 8'd128, 8'd128});

        // A width above the maximum clamps to it; shrinking it mid-row ends the row.
        wait_idle();
        write_register(ycc2rgb_pkg::CFG_LINE_WIDTH, 4095);
        queue_pixel(random_pixel());
        queue_pixel(random_pixel());
        wait_idle();
        write_register(ycc2rgb_pkg::CFG_LINE_WIDTH, 2);
        queue_pixel(random_pixel());
        finish_rows();

        // Odd width in 4:2:0 mode: the last column fetches chroma like any even one.
        wait_idle();
        write_register(ycc2rgb_pkg::CFG_SUBSAMPLE_MODE, 1);
        write_register(ycc2rgb_pkg::CFG_LINE_WIDTH, 3);
        repeat (6) queue_pixel(random_pixel());

        // A width below the minimum clamps to two.
        wait_idle();
        write_register(ycc2rgb_pkg::CFG_LINE_WIDTH, 1);
        repeat (4) queue_pixel(random_pixel());

        // Random phases; each starts at an even row so odd rows replay stored chroma.
        while (queued_items < 1200)
        begin
            wait_idle();
            if (queued_items < 400)
            begin
                sender_idle_pct <= 8;
                receiver_stall_pct <= 58;
            end
            else if (queued_items < 800)
            begin
                sender_idle_pct <= 58;
                receiver_stall_pct <= 8;
            end
            else
            begin
                sender_idle_pct <= 0;
                receiver_stall_pct <= 0;
            end

            mode = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                width_reg = $urandom_range(0, 1);
            end
            else if (pick == 1)
            begin
                width_reg = $urandom_range(25, 300);
            end
            else
            begin
                width_reg = $urandom_range(2, 24);
            end
            eff_width = (width_reg < ycc2rgb_pkg::LINE_WIDTH_MIN) ?
                        ycc2rgb_pkg::LINE_WIDTH_MIN : width_reg;
            write_register(ycc2rgb_pkg::CFG_SUBSAMPLE_MODE, mode);
            write_register(ycc2rgb_pkg::CFG_LINE_WIDTH, width_reg);

            if (mode)
            begin
                count = 2 * eff_width * $urandom_range(1, (eff_width > 24) ? 1 : 8);
                repeat (count) queue_pixel(random_pixel());
            end
            else
            begin
                count = $urandom_range(1, 3 * eff_width);
                repeat (count) queue_pixel(random_pixel());
                // Sometimes shrink the width partway through a row.
                if ($urandom_range(0, 2) == 0)
                begin
                    wait_idle();
                    write_register(ycc2rgb_pkg::CFG_LINE_WIDTH, $urandom_range(2, eff_width));
                end
                finish_rows();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
